FILE: rtl/tag_frame_parser_dedup_core_assert.svh
// ----------------------------------------------------------------------------
// tag frame parser assertion macros
// shared property forms used by the tag frame parser modules
// ----------------------------------------------------------------------------
`ifndef TAG_FRAME_PARSER_DEDUP_CORE_ASSERT_SVH
`define TAG_FRAME_PARSER_DEDUP_CORE_ASSERT_SVH

// same-cycle implication on clk, masked during reset
`define TFP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, masked during reset
`define TFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg
// types, codes and constants shared by the tag frame parser modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfp_pkg;

    // table sizing
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int EPC_BYTES       = 12;
    localparam int EPC_W           = EPC_BYTES * 8;

    // frame framing
    localparam logic [7:0]  START_BYTE   = 8'hBB;
    localparam logic [7:0]  END_BYTE     = 8'h7E;
    localparam logic [63:0] NO_TAG_FRAME = 64'hBB01FF000115167E;
    localparam logic [23:0] TAG_HEAD     = 24'hBB0222;
    localparam logic [4:0]  EPC_FIRST    = 5'd8;
    localparam logic [4:0]  EPC_END      = 5'd20;
    localparam logic [4:0]  SHORT_LEN    = 5'd8;
    localparam logic [4:0]  TAG_LEN      = 5'd24;
    localparam logic [4:0]  LEN_MAX      = 5'd31;

    // configuration port
    localparam int PADDR_W   = 6;
    localparam int PDATA_W   = 64;
    localparam int REG_LSB   = 3;
    localparam int REG_IDX_W = PADDR_W - REG_LSB;

    // register reset values
    localparam logic        RST_CONFIRM_EN = 1'b0;
    localparam logic [63:0] RST_CONFIRM    = 64'd0;
    localparam logic        RST_EPC_MODE   = 1'b1;
    localparam logic        RST_NO_TAG     = 1'b1;
    localparam logic [7:0]  RST_LIMIT      = 8'd5;
    localparam logic [15:0] RST_TIMEOUT    = 16'd1000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CONFIRM_EN = 3'd0,
        REG_CONFIRM    = 3'd1,
        REG_EPC_MODE   = 3'd2,
        REG_NO_TAG     = 3'd3,
        REG_LIMIT      = 3'd4,
        REG_TIMEOUT    = 3'd5
    } tfp_reg_t;

    typedef enum logic [3:0] {
        EV_NEW       = 4'd0,
        EV_DUP       = 4'd1,
        EV_INVALID   = 4'd2,
        EV_NO_TAG    = 4'd3,
        EV_OTHER     = 4'd4,
        EV_CONFIRMED = 4'd5,
        EV_LIMIT     = 4'd6,
        EV_TIMEOUT   = 4'd7,
        EV_FULL      = 4'd8
    } tfp_event_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WAIT = 1'b1
    } tfp_state_t;

    typedef enum logic {
        SR_IDLE = 1'b0,
        SR_SCAN = 1'b1
    } tfp_srch_state_t;

    typedef struct packed {
        logic        confirm_enable;
        logic [63:0] confirm_frame;
        logic        epc_mode;
        logic        no_tag_stop;
        logic [7:0]  no_tag_limit;
        logic [15:0] timeout_ticks;
    } tfp_cfg_t;

    typedef struct packed {
        logic done;
        logic found;
    } tfp_srch_resp_t;

endpackage

FILE: rtl/tfp_cfg.sv
// ----------------------------------------------------------------------------
// tfp_cfg
// apb register file holding the parser and session configuration
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfp_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tfp_pkg::PADDR_W-1:0] paddr,
    input  logic [tfp_pkg::PDATA_W-1:0] pwdata,
    output logic [tfp_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output tfp_pkg::tfp_cfg_t           cfg
);
    import tfp_pkg::*;

    tfp_cfg_t             cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_sel;

    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[PADDR_W-1:REG_LSB];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.confirm_enable <= RST_CONFIRM_EN;
            cfg_reg.confirm_frame  <= RST_CONFIRM;
            cfg_reg.epc_mode       <= RST_EPC_MODE;
            cfg_reg.no_tag_stop    <= RST_NO_TAG;
            cfg_reg.no_tag_limit   <= RST_LIMIT;
            cfg_reg.timeout_ticks  <= RST_TIMEOUT;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_CONFIRM_EN: cfg_reg.confirm_enable <= pwdata[0];
                REG_CONFIRM:    cfg_reg.confirm_frame  <= pwdata;
                REG_EPC_MODE:   cfg_reg.epc_mode       <= pwdata[0];
                REG_NO_TAG:     cfg_reg.no_tag_stop    <= pwdata[0];
                REG_LIMIT:      cfg_reg.no_tag_limit   <= pwdata[7:0];
                REG_TIMEOUT:    cfg_reg.timeout_ticks  <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_sel)
            REG_CONFIRM_EN: prdata = {63'd0, cfg_reg.confirm_enable};
            REG_CONFIRM:    prdata = cfg_reg.confirm_frame;
            REG_EPC_MODE:   prdata = {63'd0, cfg_reg.epc_mode};
            REG_NO_TAG:     prdata = {63'd0, cfg_reg.no_tag_stop};
            REG_LIMIT:      prdata = {56'd0, cfg_reg.no_tag_limit};
            REG_TIMEOUT:    prdata = {48'd0, cfg_reg.timeout_ticks};
            default:        prdata = '0;
        endcase
    end

endmodule

FILE: rtl/tfp_table.sv
// ----------------------------------------------------------------------------
// tfp_table
// tag table memory with a sequential search through one shared comparator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tag_frame_parser_dedup_core_assert.svh"

module tfp_table
#(
    parameter  int TABLE_DEPTH = tfp_pkg::TABLE_DEPTH_DEF,
    localparam int AW          = $clog2(TABLE_DEPTH),
    localparam int CNT_W       = AW + 1
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [tfp_pkg::EPC_W-1:0] key,
    input  logic [CNT_W-1:0]          total,
    output tfp_pkg::tfp_srch_resp_t   resp
);
    import tfp_pkg::*;

    logic [EPC_W-1:0] mem [TABLE_DEPTH];

    tfp_srch_state_t  state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             rdv_reg, rdv_next;
    logic [CNT_W-1:0] total_reg;
    logic [EPC_W-1:0] key_reg;
    logic [EPC_W-1:0] rd_reg;
    logic             rd_en;
    logic             wr_en;
    logic             hit;

    // shared comparator against the entry read last cycle
    assign hit = rdv_reg && (rd_reg == key_reg);

    // search sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rdv_next   = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        resp       = '0;
        case (state_reg)
            SR_IDLE:
            begin
                if (go)
                begin
                    state_next = SR_SCAN;
                    idx_next   = '0;
                end
            end
            SR_SCAN:
            begin
                if (idx_reg < total_reg)
                begin
                    rd_en    = 1'b1;
                    rdv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (hit)
                begin
                    resp.done  = 1'b1;
                    resp.found = 1'b1;
                    state_next = SR_IDLE;
                end
                else if (!rdv_reg && (idx_reg == total_reg))
                begin
                    resp.done  = 1'b1;
                    wr_en      = (total_reg < CNT_W'(TABLE_DEPTH));
                    state_next = SR_IDLE;
                end
            end
            default:
            begin
                state_next = SR_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SR_IDLE;
            idx_reg   <= '0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rdv_reg   <= rdv_next;
        end
    end

    // search key and entry count
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            key_reg   <= key;
            total_reg <= total;
        end
    end

    // table memory, registered read and append write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg <= mem[idx_reg[AW-1:0]];
        end
        if (wr_en)
        begin
            mem[total_reg[AW-1:0]] <= key_reg;
        end
    end

    `TFP_ASSERT_IMPL(a_go_when_idle, go, state_reg == SR_IDLE, "search started while busy")
    `TFP_ASSERT_IMPL(a_idx_bound, state_reg == SR_SCAN, idx_reg <= total_reg,
                     "search index past entry count")
    `TFP_ASSERT_NEXT(a_done_ends_scan, resp.done, state_reg == SR_IDLE,
                     "search did not stop after done")

endmodule

FILE: rtl/tag_frame_parser_dedup_core.sv
// a closing byte or timeout tick gives a registered result word in the cycle after acceptance
// a valid tag read searches the table first: its result word follows the search done response
// throughput: one byte or tick per cycle while not busy; a tag read holds busy for the table search,
// one table entry per cycle through a single registered memory read port and comparator
// reset: control state, tag count, config to defaults; payload not reset, table needs no clear
// the receiver cannot stall: each result word is shown for exactly one cycle
// ----------------------------------------------------------------------------
// tag_frame_parser_dedup_core
// reader frame parser with no-tag limit, confirmation, timeout and tag dedup table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tag_frame_parser_dedup_core_assert.svh"

module tag_frame_parser_dedup_core
#(
    parameter  int TABLE_DEPTH = tfp_pkg::TABLE_DEPTH_DEF,
    localparam int CNT_W       = $clog2(TABLE_DEPTH) + 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        mode,
    input  logic [7:0]                  data_byte,
    output logic                        result_valid,
    output logic [3:0]                  event_res,
    output logic [31:0]                 epc_upper,
    output logic [63:0]                 epc_lower,
    output logic [CNT_W-1:0]            stored_tags,
    output logic [7:0]                  empty_run,
    output logic                        session_done,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tfp_pkg::PADDR_W-1:0] paddr,
    input  logic [tfp_pkg::PDATA_W-1:0] pwdata,
    output logic [tfp_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import tfp_pkg::*;

    tfp_cfg_t       cfg;
    tfp_srch_resp_t resp;

    tfp_state_t       state_reg, state_next;
    logic             in_frame_reg, in_frame_next;
    logic [4:0]       len_reg, len_next;
    logic [63:0]      head_reg, head_next;
    logic [EPC_W-1:0] cap_reg, cap_next;
    logic [7:0]       ntc_reg, ntc_next;
    logic [15:0]      idle_reg, idle_next;
    logic [CNT_W-1:0] total_reg, total_next;

    // result word registers
    logic             result_valid_reg;
    tfp_event_t       event_reg;
    logic [EPC_W-1:0] epc_reg;
    logic [CNT_W-1:0] stored_reg;
    logic [7:0]       run_reg;
    logic             session_done_reg;

    logic             emit;
    tfp_event_t       emit_ev;
    logic [EPC_W-1:0] emit_epc;
    logic [CNT_W-1:0] emit_total;
    logic [7:0]       emit_run;
    logic             emit_done;
    logic             launch;

    // byte-in-frame updates
    logic [4:0]       len_upd;
    logic [63:0]      head_upd;
    logic [EPC_W-1:0] cap_upd;
    logic [15:0]      idle_inc;
    logic [7:0]       ntc_inc;
    logic             short_frame;

    assign len_upd  = (len_reg < LEN_MAX) ? len_reg + 5'd1 : len_reg;
    assign head_upd = (len_reg < EPC_FIRST) ? {head_reg[55:0], data_byte} : head_reg;
    assign cap_upd  = ((len_reg >= EPC_FIRST) && (len_reg < EPC_END)) ?
                      {cap_reg[EPC_W-9:0], data_byte} : cap_reg;
    assign idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign ntc_inc  = (ntc_reg == 8'hFF) ? ntc_reg : ntc_reg + 8'd1;
    assign short_frame = (len_upd == SHORT_LEN);

    tfp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tfp_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (launch),
        .key   (cap_upd),
        .total (total_reg),
        .resp  (resp)
    );

    assign busy = (state_reg != ST_IDLE);

    // parser, classifier and session control
    always_comb
    begin
        state_next    = state_reg;
        in_frame_next = in_frame_reg;
        len_next      = len_reg;
        head_next     = head_reg;
        cap_next      = cap_reg;
        ntc_next      = ntc_reg;
        idle_next     = idle_reg;
        total_next    = total_reg;
        emit          = 1'b0;
        emit_ev       = EV_OTHER;
        emit_epc      = cap_reg;
        emit_total    = total_reg;
        emit_run      = ntc_reg;
        emit_done     = 1'b0;
        launch        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && mode)
                begin
                    // time tick
                    idle_next = idle_inc;
                    if (!in_frame_reg && (idle_inc > cfg.timeout_ticks))
                    begin
                        idle_next = '0;
                        emit      = 1'b1;
                        emit_ev   = EV_TIMEOUT;
                        emit_epc  = '0;
                        emit_done = 1'b1;
                    end
                end
                else if (start)
                begin
                    idle_next = '0;
                    if (data_byte == START_BYTE)
                    begin
                        in_frame_next = 1'b1;
                        len_next      = 5'd1;
                        head_next     = {56'd0, START_BYTE};
                        cap_next      = '0;
                    end
                    else if (in_frame_reg)
                    begin
                        len_next  = len_upd;
                        head_next = head_upd;
                        cap_next  = cap_upd;
                        if (data_byte == END_BYTE)
                        begin
                            in_frame_next = 1'b0;
                            emit_epc      = cap_upd;
                            if (cfg.confirm_enable && short_frame &&
                                (head_upd == cfg.confirm_frame))
                            begin
                                emit      = 1'b1;
                                emit_ev   = EV_CONFIRMED;
                                emit_done = 1'b1;
                            end
                            else if (cfg.no_tag_stop && short_frame &&
                                     (head_upd == NO_TAG_FRAME))
                            begin
                                emit     = 1'b1;
                                emit_run = ntc_inc;
                                if (ntc_inc >= cfg.no_tag_limit)
                                begin
                                    emit_ev   = EV_LIMIT;
                                    emit_done = 1'b1;
                                    ntc_next  = '0;
                                end
                                else
                                begin
                                    emit_ev  = EV_NO_TAG;
                                    ntc_next = ntc_inc;
                                end
                            end
                            else
                            begin
                                ntc_next = '0;
                                emit_run = '0;
                                if (!cfg.epc_mode)
                                begin
                                    emit    = 1'b1;
                                    emit_ev = EV_OTHER;
                                end
                                else if ((len_upd != TAG_LEN) ||
                                         (head_upd[63:40] != TAG_HEAD))
                                begin
                                    emit    = 1'b1;
                                    emit_ev = EV_INVALID;
                                end
                                else
                                begin
                                    launch     = 1'b1;
                                    state_next = ST_WAIT;
                                end
                            end
                        end
                    end
                end
            end
            ST_WAIT:
            begin
                if (resp.done)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (resp.found)
                    begin
                        emit_ev = EV_DUP;
                    end
                    else if (total_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        emit_ev    = EV_NEW;
                        total_next = total_reg + 1'b1;
                        emit_total = total_reg + 1'b1;
                    end
                    else
                    begin
                        emit_ev = EV_FULL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            in_frame_reg     <= 1'b0;
            len_reg          <= '0;
            head_reg         <= '0;
            cap_reg          <= '0;
            ntc_reg          <= '0;
            idle_reg         <= '0;
            total_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            in_frame_reg     <= in_frame_next;
            len_reg          <= len_next;
            head_reg         <= head_next;
            cap_reg          <= cap_next;
            ntc_reg          <= ntc_next;
            idle_reg         <= idle_next;
            total_reg        <= total_next;
            result_valid_reg <= emit;
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            event_reg        <= emit_ev;
            epc_reg          <= emit_epc;
            stored_reg       <= emit_total;
            run_reg          <= emit_run;
            session_done_reg <= emit_done;
        end
    end

    assign result_valid = result_valid_reg;
    assign event_res    = event_reg;
    assign epc_upper    = epc_reg[EPC_W-1:64];
    assign epc_lower    = epc_reg[63:0];
    assign stored_tags  = stored_reg;
    assign empty_run    = run_reg;
    assign session_done = session_done_reg;

    `TFP_ASSERT_IMPL(a_done_events, result_valid_reg && session_done_reg,
                     (event_reg == EV_CONFIRMED) || (event_reg == EV_LIMIT) ||
                     (event_reg == EV_TIMEOUT), "session end on wrong event")
    `TFP_ASSERT_IMPL(a_total_bound, 1'b1, total_reg <= CNT_W'(TABLE_DEPTH),
                     "tag count past table depth")
    `TFP_ASSERT_NEXT(a_quiet_search, (state_reg == ST_WAIT) && !resp.done,
                     !result_valid_reg, "result word during table search")

endmodule
